### rtl/core/sps_pkg.sv
// shared types, codes and coil tables for the stepper phase sequencer
`timescale 1ns / 1ps

package sps_pkg;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_ADD  = 2'd1,
		CMD_STOP = 2'd2
	} cmd_t;

	// unused code 3 runs as full step
	typedef enum logic [1:0] {
		MODE_WAVE = 2'd0,
		MODE_FULL = 2'd1,
		MODE_HALF = 2'd2
	} mode_t;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MODE_BASE  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LIMIT_BASE = 3'd4;

	localparam int COUNT_IN_BITS   = 16;
	localparam int TICK_BITS       = 16;
	localparam int STEPS_OUT_BITS  = 24;
	localparam int SLOTS           = 4;

	localparam logic [3:0] WAVE_TAB [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
	localparam logic [3:0] FULL_TAB [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
	localparam logic [3:0] HALF_TAB [8] = '{4'h1, 4'h3, 4'h2, 4'h6,
		4'h4, 4'hC, 4'h8, 4'h9};

	typedef struct packed {
		logic                      tick;
		logic                      add;
		logic                      stop;
		logic [COUNT_IN_BITS-1:0]  step_count;
		logic                      direction;
		logic                      mode_we;
		logic [1:0]                mode_data;
		logic                      limit_we;
		logic [TICK_BITS-1:0]      limit_data;
	} motor_ctrl_t;

	typedef struct packed {
		logic [3:0] coils;
		logic       stepped;
		logic       busy;
	} motor_status_t;

	function automatic logic [3:0] phase_pattern(input logic [1:0] mode, input logic [2:0] idx);
		logic [3:0] pat;
		case (mode)
			MODE_WAVE: pat = WAVE_TAB[idx[1:0]];
			MODE_HALF: pat = HALF_TAB[idx];
			default:   pat = FULL_TAB[idx[1:0]];
		endcase
		return pat;
	endfunction

endpackage

### rtl/core/sps_motor.sv
// per-motor state: mode, limit, phase, queued steps, tick counter and coils
`timescale 1ns / 1ps

module sps_motor import sps_pkg::*; #(
	parameter int STEP_COUNT_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  motor_ctrl_t                ctrl,
	output motor_status_t              status,
	output logic [STEP_COUNT_BITS-1:0] pending
);

	localparam int SUM_BITS = STEP_COUNT_BITS + 1;

	logic [1:0]                 mode_q;
	logic [TICK_BITS-1:0]       limit_q;
	logic [2:0]                 idx_q, idx_d, idx_next;
	logic [STEP_COUNT_BITS-1:0] pend_q, pend_d;
	logic [TICK_BITS-1:0]       tick_q, tick_d;
	logic                       dir_q, dir_d;
	logic [3:0]                 coils_q, coils_d;
	logic                       fire;
	logic                       stepped;
	logic [SUM_BITS-1:0]        add_sum;

	assign fire    = (tick_q >= limit_q) && (pend_q != '0);
	assign add_sum = {1'b0, pend_q} + SUM_BITS'(ctrl.step_count);

	// 4-phase modes wrap on two bits, half step on three
	always_comb begin
		if (mode_q == MODE_HALF) begin
			idx_next = dir_q ? idx_q - 3'd1 : idx_q + 3'd1;
		end else begin
			idx_next = {1'b0, (dir_q ? idx_q[1:0] - 2'd1 : idx_q[1:0] + 2'd1)};
		end
	end

	always_comb begin
		pend_d  = pend_q;
		tick_d  = tick_q;
		idx_d   = idx_q;
		coils_d = coils_q;
		dir_d   = dir_q;
		stepped = 1'b0;
		if (ctrl.tick) begin
			if (fire) begin
				coils_d = phase_pattern(mode_q, idx_q);
				idx_d   = idx_next;
				pend_d  = pend_q - STEP_COUNT_BITS'(1);
				tick_d  = '0;
				stepped = 1'b1;
			end else if (tick_q != '1) begin
				tick_d = tick_q + TICK_BITS'(1);
			end
		end else if (ctrl.add) begin
			// saturate at the top of the queue counter
			pend_d = add_sum[STEP_COUNT_BITS] ? '1 : add_sum[STEP_COUNT_BITS-1:0];
			dir_d  = ctrl.direction;
		end else if (ctrl.stop) begin
			pend_d = '0;
		end
		if (ctrl.mode_we) begin
			idx_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_FULL;
			limit_q <= '0;
			idx_q   <= '0;
			pend_q  <= '0;
			tick_q  <= '0;
			dir_q   <= 1'b0;
			coils_q <= '0;
		end else begin
			if (ctrl.mode_we) begin
				mode_q <= ctrl.mode_data;
			end
			if (ctrl.limit_we) begin
				limit_q <= ctrl.limit_data;
			end
			idx_q   <= idx_d;
			pend_q  <= pend_d;
			tick_q  <= tick_d;
			dir_q   <= dir_d;
			coils_q <= coils_d;
		end
	end

	assign status.coils   = coils_d;
	assign status.stepped = stepped;
	assign status.busy    = (pend_d != '0);
	assign pending        = pend_d;

endmodule

### rtl/core/stepper_phase_sequencer.sv
// top level of the four-motor unipolar stepper phase sequencer
`timescale 1ns / 1ps

// commands come in on cmd_valid/cmd_ready: a time base tick, an add of
// steps with a direction, or a stop; add and stop go to the motor picked
// by motor_sel, a tick to all motors. every command transfer gives exactly
// one result on res_valid/res_ready: the held coil levels of all motors,
// which motors stepped, which still have steps queued, and the queued
// count of the addressed motor. the motor state and the result register
// update at the edge that takes the command. throughput is one command per
// cycle; the only limit is the single result register, so cmd_ready drops
// only while a result waits and res_ready is low, and comes back as soon
// as the receiver takes it. mode and limit registers are written through
// cfg_we/cfg_index/cfg_data; the user must do so only while no command is
// in flight; the block does not enforce it. a mode write returns that
// motor to phase zero. reset puts every motor in full step with limit
// zero, no steps queued, all coils off, and empties the result register.
module stepper_phase_sequencer import sps_pkg::*; #(
	parameter int MOTORS          = 4,
	parameter int STEP_COUNT_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  logic [1:0]                cmd,
	input  logic [1:0]                motor_sel,
	input  logic [COUNT_IN_BITS-1:0]  step_count,
	input  logic                      direction,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [15:0]               coil_drive,
	output logic [3:0]                stepped_mask,
	output logic [3:0]                busy_mask,
	output logic [STEPS_OUT_BITS-1:0] steps_left
);

	logic                  accept;
	logic                  res_valid_q;
	logic [15:0]           coil_drive_q;
	logic [3:0]            stepped_mask_q;
	logic [3:0]            busy_mask_q;
	logic [STEPS_OUT_BITS-1:0] steps_left_q;
	logic                  is_mode_reg;
	logic [1:0]            cfg_motor;
	logic                  sel_ok;
	logic [15:0]           coils_all;
	logic [3:0]            stepped_all;
	logic [3:0]            busy_all;
	logic [STEPS_OUT_BITS-1:0] pend_all [SLOTS];

	assign cmd_ready   = !res_valid_q || res_ready;
	assign accept      = cmd_valid && cmd_ready;
	assign is_mode_reg = (cfg_index < REG_LIMIT_BASE);
	assign cfg_motor   = cfg_index[1:0];
	assign sel_ok      = ({1'b0, motor_sel} < 3'(MOTORS));

	for (genvar m = 0; m < SLOTS; m++) begin : g_motor
		if (m < MOTORS) begin : g_on
			motor_ctrl_t                ctrl;
			motor_status_t              status;
			logic [STEP_COUNT_BITS-1:0] pending;

			always_comb begin
				ctrl.tick       = accept && (cmd == CMD_TICK);
				ctrl.add        = accept && (cmd == CMD_ADD) && (motor_sel == 2'(m));
				ctrl.stop       = accept && (cmd == CMD_STOP) && (motor_sel == 2'(m));
				ctrl.step_count = step_count;
				ctrl.direction  = direction;
				ctrl.mode_we    = cfg_we && is_mode_reg && (cfg_motor == 2'(m));
				ctrl.mode_data  = cfg_data[1:0];
				ctrl.limit_we   = cfg_we && !is_mode_reg && (cfg_motor == 2'(m));
				ctrl.limit_data = cfg_data;
			end

			sps_motor #(
				.STEP_COUNT_BITS(STEP_COUNT_BITS)
			) u_motor (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (ctrl),
				.status (status),
				.pending(pending)
			);

			assign coils_all[4*m +: 4] = status.coils;
			assign stepped_all[m]      = status.stepped;
			assign busy_all[m]         = status.busy;
			assign pend_all[m]         = STEPS_OUT_BITS'(pending);
		end else begin : g_off
			assign coils_all[4*m +: 4] = '0;
			assign stepped_all[m]      = 1'b0;
			assign busy_all[m]         = 1'b0;
			assign pend_all[m]         = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			coil_drive_q   <= coils_all;
			stepped_mask_q <= stepped_all;
			busy_mask_q    <= busy_all;
			steps_left_q   <= sel_ok ? pend_all[motor_sel] : '0;
		end
	end

	assign res_valid    = res_valid_q;
	assign coil_drive   = coil_drive_q;
	assign stepped_mask = stepped_mask_q;
	assign busy_mask    = busy_mask_q;
	assign steps_left   = steps_left_q;

endmodule
